// ===== rtl/cca_pkg.sv =====
// Shared types and constants of the cluster centroid accumulator.
package cca_pkg;

  localparam int COORD_W           = 24;
  localparam int ID_W              = 7;
  localparam int OCNT_W            = 17;
  localparam int CLUSTER_SLOTS_DEF = 64;
  localparam int MAX_POINTS_DEF    = 65536;
  localparam int QUEUE_DEPTH       = 4;
  localparam int QPTR_W            = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [ID_W-1:0]           slot;
    logic                      acc;
    logic                      last;
  } item_t;

  typedef enum logic [1:0] {
    BK_ACC,
    BK_SCAN,
    BK_LOAD,
    BK_DIV
  } back_state_t;

endpackage

// ===== rtl/cca_front.sv =====
// Front end: takes input items, checks the label range and forms queue entries.
module cca_front import cca_pkg::*; #(
  parameter int CLUSTER_SLOTS = CLUSTER_SLOTS_DEF
) (
  input  logic                      start,
  input  logic                      full,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic signed [ID_W-1:0]    cluster_id,
  input  logic                      last_point,
  output logic                      push,
  output item_t                     push_item
);

  logic in_range;

  always_comb begin
    in_range = (int'(cluster_id) >= -1) && (int'(cluster_id) <= CLUSTER_SLOTS - 2);
    push_item.x    = x_coord;
    push_item.y    = y_coord;
    push_item.slot = cluster_id + ID_W'(1);
    push_item.acc  = in_range;
    push_item.last = last_point;
    // an out-of-range point without the last mark changes nothing
    push = start && !full && (in_range || last_point);
  end

endmodule

// ===== rtl/cca_fifo.sv =====
// Short item queue between front end and accumulator.
module cca_fifo import cca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  item_t push_item,
  input  logic  pop,
  output logic  full,
  output logic  valid,
  output item_t item
);

  item_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr;
  logic [QPTR_W-1:0]    rd_ptr;
  logic [QPTR_W:0]      fill;

  assign full  = (fill == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid = (fill != '0);
  assign item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== rtl/cca_div.sv =====
// Restoring divider, one quotient bit per cycle, truncates toward zero.
module cca_div #(
  parameter int DVD_W = 41,
  parameter int DVS_W = 17
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]        divisor,
  output logic                    done,
  output logic signed [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic               running;
  logic [CNT_W-1:0]   steps;
  logic [DVS_W:0]     rem;
  logic [DVD_W-1:0]   acc;
  logic [DVS_W-1:0]   dvs;
  logic               neg;
  logic [DVS_W:0]     trial;
  logic               ge;

  always_comb begin
    trial    = {rem[DVS_W-1:0], acc[DVD_W-1]};
    ge       = (trial >= {1'b0, dvs});
    quotient = neg ? -$signed(acc) : $signed(acc);
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= dividend[DVD_W-1] ? DVD_W'(-dividend) : dividend;
      neg <= dividend[DVD_W-1];
      dvs <= divisor;
      rem <= '0;
    end else if (running) begin
      rem <= ge ? (trial - {1'b0, dvs}) : trial;
      acc <= {acc[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      steps   <= '0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        running <= 1'b1;
        steps   <= CNT_W'(DVD_W);
      end else if (running) begin
        steps <= steps - CNT_W'(1);
        if (steps == CNT_W'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/cca_back.sv =====
// Back end: per-slot sums and counts, and the centroid drain after a last item.
module cca_back import cca_pkg::*; #(
  parameter int CLUSTER_SLOTS = CLUSTER_SLOTS_DEF,
  parameter int MAX_POINTS    = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      q_valid,
  input  item_t                     q_item,
  output logic                      pop,
  output logic                      result_strobe,
  output logic signed [COORD_W-1:0] center_x,
  output logic signed [COORD_W-1:0] center_y,
  output logic signed [ID_W-1:0]    center_id,
  output logic [OCNT_W-1:0]         member_count,
  output logic                      last_center
);

  localparam int SLOT_W = (CLUSTER_SLOTS > 1) ? $clog2(CLUSTER_SLOTS) : 1;
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);
  localparam int SUM_W  = COORD_W + CNT_W;
  localparam int ENT_W  = 2 * SUM_W + CNT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(CLUSTER_SLOTS - 1);

  back_state_t state, state_next;

  logic [ENT_W-1:0]         store [CLUSTER_SLOTS];
  logic [ENT_W-1:0]         rd_q;
  logic [SLOT_W-1:0]        rd_addr;
  logic [CLUSTER_SLOTS-1:0] filled;

  logic                     b_valid;
  item_t                    b_item;
  logic [SLOT_W-1:0]        b_slot;

  logic                     pw_valid;
  logic [SLOT_W-1:0]        pw_slot;
  logic [ENT_W-1:0]         pw_data;

  logic [ENT_W-1:0]         cur;
  logic signed [SUM_W-1:0]  cur_sx;
  logic signed [SUM_W-1:0]  cur_sy;
  logic [CNT_W-1:0]         cur_cnt;
  logic [ENT_W-1:0]         wr_data;
  logic                     do_wr;

  logic [SLOT_W-1:0]        scan_slot;
  logic                     higher_filled;
  logic                     div_go;
  logic                     done_x;
  logic                     done_y;
  logic signed [SUM_W-1:0]  quo_x;
  logic signed [SUM_W-1:0]  quo_y;
  logic [CNT_W-1:0]         div_cnt;
  logic [OCNT_W+CNT_W-1:0]  cnt_ext;
  logic                     emit;
  logic                     scan_step;
  logic                     finish;

  assign b_slot = b_item.slot[SLOT_W-1:0];

  // read-modify-write with bypass of the write made in the cycle before
  always_comb begin
    if (pw_valid && (pw_slot == b_slot)) begin
      cur = pw_data;
    end else if (filled[b_slot]) begin
      cur = rd_q;
    end else begin
      cur = '0;
    end
    cur_sx  = cur[SUM_W-1:0];
    cur_sy  = cur[2*SUM_W-1:SUM_W];
    cur_cnt = cur[ENT_W-1:2*SUM_W];
    do_wr   = b_valid && b_item.acc && (cur_cnt < CNT_W'(MAX_POINTS));
    wr_data = {cur_cnt + CNT_W'(1),
               cur_sy + {{(SUM_W-COORD_W){b_item.y[COORD_W-1]}}, b_item.y},
               cur_sx + {{(SUM_W-COORD_W){b_item.x[COORD_W-1]}}, b_item.x}};
  end

  always_comb begin
    higher_filled = 1'b0;
    for (int i = 0; i < CLUSTER_SLOTS; i++) begin
      if (filled[i] && (SLOT_W'(i) > scan_slot)) begin
        higher_filled = 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    rd_addr    = q_item.slot[SLOT_W-1:0];
    div_go     = 1'b0;
    emit       = 1'b0;
    scan_step  = 1'b0;
    finish     = 1'b0;
    unique case (state)
      BK_ACC: begin
        pop = q_valid && !(b_valid && b_item.last);
        if (b_valid && b_item.last) begin
          state_next = BK_SCAN;
        end
      end
      BK_SCAN: begin
        rd_addr = scan_slot;
        if (filled[scan_slot]) begin
          state_next = BK_LOAD;
        end else if (scan_slot == LAST_SLOT) begin
          finish     = 1'b1;
          state_next = BK_ACC;
        end else begin
          scan_step = 1'b1;
        end
      end
      BK_LOAD: begin
        rd_addr    = scan_slot;
        div_go     = 1'b1;
        state_next = BK_DIV;
      end
      BK_DIV: begin
        rd_addr = scan_slot;
        if (done_x) begin
          emit = 1'b1;
          if (!higher_filled || (scan_slot == LAST_SLOT)) begin
            finish     = 1'b1;
            state_next = BK_ACC;
          end else begin
            scan_step  = 1'b1;
            state_next = BK_SCAN;
          end
        end
      end
      default: state_next = BK_ACC;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_ACC;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[b_slot] <= wr_data;
    end
    rd_q <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    b_item  <= q_item;
    pw_slot <= b_slot;
    pw_data <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      pw_valid  <= 1'b0;
      filled    <= '0;
      scan_slot <= '0;
    end else begin
      b_valid  <= pop;
      pw_valid <= do_wr;
      if (state == BK_ACC) begin
        scan_slot <= '0;
      end else if (scan_step) begin
        scan_slot <= scan_slot + SLOT_W'(1);
      end
      if (finish) begin
        filled <= '0;
      end else if (do_wr) begin
        filled[b_slot] <= 1'b1;
      end
    end
  end

  assign div_cnt = rd_q[ENT_W-1:2*SUM_W];

  cca_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div_x (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (rd_q[SUM_W-1:0]),
    .divisor  (div_cnt),
    .done     (done_x),
    .quotient (quo_x)
  );

  cca_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div_y (
    .clk      (clk),
    .rst      (rst),
    .go       (div_go),
    .dividend (rd_q[2*SUM_W-1:SUM_W]),
    .divisor  (div_cnt),
    .done     (done_y),
    .quotient (quo_y)
  );

  assign cnt_ext = {{OCNT_W{1'b0}}, rd_q[ENT_W-1:2*SUM_W]};

  always_ff @(posedge clk) begin
    if (emit) begin
      center_x     <= quo_x[COORD_W-1:0];
      center_y     <= quo_y[COORD_W-1:0];
      center_id    <= {{(ID_W-SLOT_W){1'b0}}, scan_slot} - ID_W'(1);
      member_count <= cnt_ext[OCNT_W-1:0];
      last_center  <= !higher_filled;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= emit && done_y;
    end
  end

endmodule

// ===== rtl/cluster_centroid_accumulator.sv =====
// Top level of the per-label centroid accumulator.
//
// Input: an item (x_coord, y_coord, cluster_id, last_point) is taken at a
// rising edge with start high and busy low. Items go through a four-entry
// queue into the accumulator, which, except while it drains centroids, adds
// one point per cycle into the sums of its label (noise, -1, is its own label);
// labels outside the slot range only count for their last mark. busy is high
// while the queue is full. Output: after an item with last_point set has been
// added, one centroid per non-empty label comes out in ascending label order,
// each for one cycle with result_strobe high; last_center marks the final one.
// The receiver cannot stall. Each centroid goes through the bit-serial divider
// over the sum width (COORD_W plus the count width, 41 at the defaults), and
// each empty slot on the way costs a scan step. Items arriving meanwhile wait
// in the queue. The store is then emptied at once through its fill bits.
// Reset empties queue and store; no results are pending after it.
module cluster_centroid_accumulator import cca_pkg::*; #(
  parameter int CLUSTER_SLOTS = CLUSTER_SLOTS_DEF,
  parameter int MAX_POINTS    = MAX_POINTS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [COORD_W-1:0] x_coord,
  input  logic signed [COORD_W-1:0] y_coord,
  input  logic signed [ID_W-1:0]    cluster_id,
  input  logic                      last_point,
  output logic                      result_strobe,
  output logic signed [COORD_W-1:0] center_x,
  output logic signed [COORD_W-1:0] center_y,
  output logic signed [ID_W-1:0]    center_id,
  output logic [OCNT_W-1:0]         member_count,
  output logic                      last_center
);

  logic  push;
  item_t push_item;
  logic  pop;
  logic  q_valid;
  item_t q_item;

  cca_front #(
    .CLUSTER_SLOTS(CLUSTER_SLOTS)
  ) u_front (
    .start      (start),
    .full       (busy),
    .x_coord    (x_coord),
    .y_coord    (y_coord),
    .cluster_id (cluster_id),
    .last_point (last_point),
    .push       (push),
    .push_item  (push_item)
  );

  cca_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (busy),
    .valid     (q_valid),
    .item      (q_item)
  );

  cca_back #(
    .CLUSTER_SLOTS(CLUSTER_SLOTS),
    .MAX_POINTS   (MAX_POINTS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .pop           (pop),
    .result_strobe (result_strobe),
    .center_x      (center_x),
    .center_y      (center_y),
    .center_id     (center_id),
    .member_count  (member_count),
    .last_center   (last_center)
  );

endmodule

// ===== rtl/cca_checker.sv =====
// Port-level checks of the centroid accumulator, bound to the top level.
module cca_checker import cca_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      start,
  input logic                      busy,
  input logic                      result_strobe,
  input logic signed [ID_W-1:0]    center_id,
  input logic                      last_center
);

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> (!result_strobe && !busy))
    else $error("result or busy right after reset");

  a_results_spaced: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("two centroids in adjacent cycles");

  a_top_label_final: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && (center_id == 7'sd62)) |-> last_center)
    else $error("highest label not marked final");

  a_busy_needs_start: assert property (@(posedge clk) disable iff (rst)
    ($rose(busy) && !$past(rst)) |-> $past(start))
    else $error("queue filled without an item");

endmodule

bind cluster_centroid_accumulator cca_checker u_cca_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .result_strobe (result_strobe),
  .center_id     (center_id),
  .last_center   (last_center)
);

// ===== test/tb_cluster_centroid_accumulator.sv =====
// Self-checking testbench for cluster_centroid_accumulator: directed and random point sets.
module tb_cluster_centroid_accumulator;
  import cca_pkg::*;

  localparam int SLOTS = CLUSTER_SLOTS_DEF;
  localparam int CAP   = MAX_POINTS_DEF;
  localparam int XMAX  = 8388607;
  localparam int XMIN  = -8388608;

  typedef struct {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [ID_W-1:0]    cid;
    logic [OCNT_W-1:0]         count;
    logic                      tail;
  } centroid_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [ID_W-1:0]    id;
    logic                      last;
    bit                        typed;
    int                        nres;
    centroid_t                 want;
  } point_row_t;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;
  logic signed [ID_W-1:0]    cluster_id;
  logic                      last_point;
  logic                      result_strobe;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic signed [ID_W-1:0]    center_id;
  logic [OCNT_W-1:0]         member_count;
  logic                      last_center;

  cluster_centroid_accumulator #(
    .CLUSTER_SLOTS(SLOTS),
    .MAX_POINTS   (CAP)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .x_coord      (x_coord),
    .y_coord      (y_coord),
    .cluster_id   (cluster_id),
    .last_point   (last_point),
    .result_strobe(result_strobe),
    .center_x     (center_x),
    .center_y     (center_y),
    .center_id    (center_id),
    .member_count (member_count),
    .last_center  (last_center)
  );

  logic signed [39:0] x_total [SLOTS];
  logic signed [39:0] y_total [SLOTS];
  logic [OCNT_W-1:0]  members [SLOTS];

  centroid_t  fresh[$];
  centroid_t  centroids_due[$];
  point_row_t on_port;
  point_row_t script[$];
  centroid_t  got;
  centroid_t  oldest;
  int         errors;
  int         points_sent;
  bit         steady;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  initial begin
    #(8 * 10000000);
    $display("FAILURE");
    $finish;
  end

  function automatic point_row_t row(input int x, input int y, input int id, input bit last);
    point_row_t r;
    r.x     = COORD_W'(x);
    r.y     = COORD_W'(y);
    r.id    = ID_W'(id);
    r.last  = last;
    r.typed = 1'b0;
    r.nres  = 0;
    r.want  = '{default: '0};
    return r;
  endfunction

  // expected outcome written out: nres is 0 or a single closing centroid
  function automatic point_row_t typed_row(input int x, input int y, input int id, input bit last,
                                           input int nres, input int cx, input int cy,
                                           input int cid, input int cnt);
    point_row_t r;
    r            = row(x, y, id, last);
    r.typed      = 1'b1;
    r.nres       = nres;
    r.want.cx    = COORD_W'(cx);
    r.want.cy    = COORD_W'(cy);
    r.want.cid   = ID_W'(cid);
    r.want.count = OCNT_W'(cnt);
    r.want.tail  = 1'b1;
    return r;
  endfunction

  function automatic int rand_coord();
    case ($urandom_range(7, 0))
      0:       return XMAX;
      1:       return XMIN;
      2:       return $urandom_range(1, 0) ? 0 : -1;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic int stray_id();
    return $urandom_range(1, 0) ? 63 : -int'($urandom_range(64, 2));
  endfunction

  task automatic wipe_store();
    for (int s = 0; s < SLOTS; s++) begin
      x_total[s] = '0;
      y_total[s] = '0;
      members[s] = '0;
    end
  endtask

  task automatic absorb_point(input logic signed [COORD_W-1:0] px,
                              input logic signed [COORD_W-1:0] py,
                              input logic signed [ID_W-1:0] pid, input logic plast);
    int        slot;
    int        tail;
    centroid_t c;
    slot = int'(pid) + 1;
    if (slot >= 0 && slot < SLOTS && members[slot] < CAP) begin
      x_total[slot] = x_total[slot] + px;
      y_total[slot] = y_total[slot] + py;
      members[slot] = members[slot] + 1'b1;
    end
    if (plast) begin
      tail = -1;
      for (int s = 0; s < SLOTS; s++)
        if (members[s] != 0) tail = s;
      for (int s = 0; s < SLOTS; s++) begin
        if (members[s] != 0) begin
          c.cx    = COORD_W'(longint'(x_total[s]) / longint'(members[s]));
          c.cy    = COORD_W'(longint'(y_total[s]) / longint'(members[s]));
          c.cid   = ID_W'(s - 1);
          c.count = members[s];
          c.tail  = (s == tail);
          fresh   = {fresh, c};
        end
      end
      wipe_store();
    end
  endtask

  task automatic check_field(input string what, input logic signed [31:0] want,
                             input logic signed [31:0] seen);
    if (seen !== want) begin
      $display("%0t %s mismatch: expected %0d, actual %0d", $time, what, want, seen);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (result_strobe) begin
        got.cx    = center_x;
        got.cy    = center_y;
        got.cid   = center_id;
        got.count = member_count;
        got.tail  = last_center;
        if (centroids_due.size() == 0) begin
          $display("%0t unexpected centroid: expected none, actual id %0d x %0d y %0d n %0d",
                   $time, got.cid, got.cx, got.cy, got.count);
          errors++;
        end else begin
          oldest = centroids_due.pop_front();
          check_field("center_x", oldest.cx, got.cx);
          check_field("center_y", oldest.cy, got.cy);
          check_field("center_id", oldest.cid, got.cid);
          check_field("member_count", oldest.count, got.count);
          check_field("last_center", oldest.tail, got.tail);
        end
      end
      if (start && !busy) begin
        fresh.delete();
        absorb_point(x_coord, y_coord, cluster_id, last_point);
        if (on_port.typed) begin
          fresh.delete();
          if (on_port.nres != 0) fresh = {fresh, on_port.want};
        end
        foreach (fresh[i]) centroids_due = {centroids_due, fresh[i]};
      end
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_point(input point_row_t r);
    while (!steady && $urandom_range(99, 0) < 27) begin
      start = 1'b0;
      @(negedge clk);
    end
    on_port    = r;
    x_coord    = r.x;
    y_coord    = r.y;
    cluster_id = r.id;
    last_point = r.last;
    start      = 1'b1;
    do @(posedge clk); while (busy);
    points_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    start = 1'b0;
    while (centroids_due.size() != 0) @(negedge clk);
  endtask

  // labels drawn from a window of `spread` slots; optionally close on an out-of-range label
  task automatic send_set(input int n, input int spread, input bit stray_tail);
    int         lo;
    int         id;
    point_row_t r;
    lo = $urandom_range(SLOTS - spread, 0);
    for (int i = 0; i < n; i++) begin
      id = lo + $urandom_range(spread - 1, 0) - 1;
      if (stray_tail && i == n - 1) id = stray_id();
      r = row(rand_coord(), rand_coord(), id, i == n - 1);
      send_point(r);
    end
  endtask

  initial begin
    int         kind;
    int         order[SLOTS];
    int         tmp;
    int         j;
    int         random_base;
    int         waited;
    point_row_t r;

    errors      = 0;
    points_sent = 0;
    steady      = 1'b0;
    rst         = 1'b1;
    start       = 1'b0;
    x_coord     = '0;
    y_coord     = '0;
    cluster_id  = '0;
    last_point  = 1'b0;
    on_port     = row(0, 0, 0, 1'b0);
    wipe_store();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    script = {
      typed_row(XMAX, XMIN, 62, 1'b1, 1, XMAX, XMIN, 62, 1),
      typed_row(XMIN, XMAX, -1, 1'b1, 1, XMIN, XMAX, -1, 1),
      typed_row(0, 0, -2, 1'b1, 0, 0, 0, 0, 0),
      typed_row(5, 5, 63, 1'b1, 0, 0, 0, 0, 0),
      typed_row(1, -1, -64, 1'b1, 0, 0, 0, 0, 0),
      row(XMAX, XMAX, 0, 1'b0),
      typed_row(XMAX, XMAX, 0, 1'b1, 1, XMAX, XMAX, 0, 2),
      row(XMIN, XMIN, 61, 1'b0),
      row(XMIN, XMIN, 61, 1'b0),
      typed_row(XMIN, XMIN, 61, 1'b1, 1, XMIN, XMIN, 61, 3),
      row(-3, 7, 3, 1'b0),
      row(0, 0, 3, 1'b0),
      row(100, -100, -1, 1'b0),
      row(7, 7, -5, 1'b1),
      row(-1, -1, 10, 1'b0),
      row(-1, 0, 10, 1'b0),
      row(0, -2, 10, 1'b0),
      row(XMAX, XMIN, 40, 1'b0),
      row(XMIN, XMAX, 40, 1'b0),
      row(9, 9, 63, 1'b0),
      row(3, -3, -1, 1'b1)
    };
    foreach (script[i]) send_point(script[i]);
    drain();

    // every label once, shuffled
    for (int s = 0; s < SLOTS; s++) order[s] = s - 1;
    for (int s = SLOTS - 1; s > 0; s--) begin
      j        = $urandom_range(s, 0);
      tmp      = order[s];
      order[s] = order[j];
      order[j] = tmp;
    end
    for (int s = 0; s < SLOTS; s++)
      send_point(row(rand_coord(), rand_coord(), order[s], s == SLOTS - 1));

    random_base = points_sent;
    while (points_sent < random_base + 300) begin
      steady = (points_sent - random_base >= 150) && (points_sent - random_base < 230);
      kind   = $urandom_range(99, 0);
      if (kind < 55)
        send_set($urandom_range(24, 1), $urandom_range(8, 1), 1'b0);
      else if (kind < 65)
        send_set($urandom_range(40, 1), SLOTS, 1'b0);
      else if (kind < 77)
        send_set($urandom_range(16, 2), $urandom_range(6, 1), 1'b1);
      else if (kind < 85)
        send_point(row(rand_coord(), rand_coord(), stray_id(), 1'b1));
      else begin
        r = row(int'($urandom), int'($urandom), int'($urandom), $urandom_range(9, 0) == 0);
        send_point(r);
      end
    end
    steady = 1'b0;
    drain();

    send_set($urandom_range(12, 2), 4, 1'b0);

    start  = 1'b0;
    waited = 0;
    while (centroids_due.size() != 0 && waited < 400000) begin
      @(posedge clk);
      waited++;
    end
    repeat (200) @(posedge clk);
    if (centroids_due.size() != 0) begin
      $display("%0t %0d centroids never arrived, oldest id %0d", $time,
               centroids_due.size(), centroids_due[0].cid);
      errors++;
    end
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
